FILE: sv/tcpu_pkg.sv
`timescale 1ns / 1ps

package tcpu_pkg;

    // Word memory geometry. The depth is a power of two, so wrapping an
    // address is taking its low bits.
    localparam int MEM_WORDS = 8192;
    localparam int ADDR_W    = $clog2(MEM_WORDS);
    localparam int NUM_REGS  = 16;
    localparam int REG_IDX_W = 4;

    typedef logic [15:0]       word_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [3:0]        reg_idx_t;

    localparam reg_idx_t REG_SP    = 4'd14;
    localparam reg_idx_t REG_PC    = 4'd15;
    localparam word_t    SP_RESET  = 16'(MEM_WORDS - 1);
    localparam word_t    HALT_WORD = 16'hFFFF;

    // Request kinds.
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    typedef enum logic [3:0] {
        OP_JMP  = 4'h0,
        OP_JCC  = 4'h1,
        OP_LDR  = 4'h2,
        OP_STR  = 4'h3,
        OP_MOV  = 4'h4,
        OP_ADD  = 4'h5,
        OP_ADDI = 4'h6,
        OP_SUB  = 4'h7,
        OP_SUBI = 4'h8,
        OP_AND  = 4'h9,
        OP_OR   = 4'hA,
        OP_SHR  = 4'hB,
        OP_SHL  = 4'hC,
        OP_CMP  = 4'hD,
        OP_PUSH = 4'hE,
        OP_POP  = 4'hF
    } opcode_t;

    typedef enum logic [1:0] {
        CC_EQ = 2'd0,
        CC_NE = 2'd1,
        CC_LT = 2'd2,
        CC_GE = 2'd3
    } cond_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EXEC,
        ST_MEM,
        ST_DONE
    } state_t;

    // What the execute stage decides for one instruction.
    typedef struct packed {
        word_t    pc_next;
        word_t    sp_next;
        logic     z_next;
        logic     c_next;
        logic     halt;
        logic     wr_reg;
        reg_idx_t wr_idx;
        word_t    wr_val;
        logic     wr_mem;
        logic     mem_rd;
        addr_t    mem_addr;
        word_t    mem_val;
    } exec_t;

    // Write report of one step.
    typedef struct packed {
        logic        reg_written;
        reg_idx_t    reg_index;
        word_t       reg_value;
        logic        mem_written;
        logic [12:0] mem_addr;
        word_t       mem_value;
    } report_t;

    typedef struct packed {
        word_t   pc_value;
        logic    zero_flag_out;
        logic    carry_flag_out;
        logic    is_halted;
        report_t rep;
    } rsp_t;

    // Wrap an address sum into the word memory.
    function automatic addr_t wrap_addr(input logic [16:0] sum);
        return sum[ADDR_W-1:0];
    endfunction

endpackage

FILE: sv/tcpu_req_if.sv
`timescale 1ns / 1ps

interface tcpu_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [12:0] load_addr;
    logic [15:0] load_data;

    modport source (output valid, output req_type, output load_addr, output load_data,
                    input ready);
    modport sink (input valid, input req_type, input load_addr, input load_data,
                  output ready);
endinterface

FILE: sv/tcpu_rsp_if.sv
`timescale 1ns / 1ps

interface tcpu_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] pc_value;
    logic        zero_flag_out;
    logic        carry_flag_out;
    logic        is_halted;
    logic        reg_written;
    logic [3:0]  reg_index;
    logic [15:0] reg_value;
    logic        mem_written;
    logic [12:0] mem_addr;
    logic [15:0] mem_value;

    modport source (output valid, output pc_value, output zero_flag_out,
                    output carry_flag_out, output is_halted, output reg_written,
                    output reg_index, output reg_value, output mem_written,
                    output mem_addr, output mem_value, input ready);
    modport sink (input valid, input pc_value, input zero_flag_out,
                  input carry_flag_out, input is_halted, input reg_written,
                  input reg_index, input reg_value, input mem_written,
                  input mem_addr, input mem_value, output ready);
endinterface

FILE: sv/tcpu_ram.sv
`timescale 1ns / 1ps

module tcpu_ram #(
    parameter int DEPTH = 8192,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single port, read before write, registered read data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: sv/tcpu_regfile.sv
`timescale 1ns / 1ps

module tcpu_regfile
    import tcpu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  reg_idx_t ra_a,
    input  reg_idx_t ra_b,
    input  logic     we,
    input  reg_idx_t wa,
    input  word_t    wd,
    output word_t    rd_a,
    output word_t    rd_b
);

    word_t mem [NUM_REGS];
    logic [NUM_REGS-1:0] valid_reg;

    // Valid bits make every register read as zero after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[wa] <= 1'b1;
        end
    end

    // Two registered read ports and one write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_a <= valid_reg[ra_a] ? mem[ra_a] : '0;
        rd_b <= valid_reg[ra_b] ? mem[ra_b] : '0;
    end

endmodule

FILE: sv/tcpu_alu.sv
`timescale 1ns / 1ps

module tcpu_alu
    import tcpu_pkg::*;
(
    input  word_t instr,
    input  word_t a,
    input  word_t b,
    input  word_t pc,
    input  word_t sp,
    input  logic  z,
    input  logic  c,
    output exec_t ex
);

    opcode_t     op;
    reg_idx_t    rd;
    logic [3:0]  i4;
    logic [16:0] sum;
    logic [16:0] diff;
    word_t       sub_b;
    word_t       sp_inc;
    logic        take;

    assign op     = opcode_t'(instr[3:0]);
    assign rd     = instr[15:12];
    assign i4     = instr[7:4];
    assign sum    = {1'b0, a} + {1'b0, (op == OP_ADD) ? b : {12'b0, i4}};
    assign sub_b  = (op == OP_SUBI) ? {12'b0, i4} : b;
    assign diff   = {1'b0, a} - {1'b0, sub_b};
    assign sp_inc = sp + 16'd1;

    // Branch condition on the current flags.
    always_comb
    begin
        case (cond_t'(instr[15:14]))
            CC_EQ:   take = z;
            CC_NE:   take = !z;
            CC_LT:   take = !z && c;
            CC_GE:   take = z || !c;
            default: take = 1'b0;
        endcase
    end

    // Decode and execute one instruction.
    always_comb
    begin
        ex         = '0;
        ex.pc_next = pc;
        ex.sp_next = sp;
        ex.z_next  = z;
        ex.c_next  = c;
        case (op)
            OP_JMP:
            begin
                ex.pc_next = pc + {4'b0, instr[15:4]};
            end
            OP_JCC:
            begin
                if (take)
                begin
                    ex.pc_next = pc + {6'b0, instr[13:4]};
                end
            end
            OP_LDR:
            begin
                ex.mem_rd   = 1'b1;
                ex.mem_addr = wrap_addr(17'(a) + 17'(i4));
                ex.wr_reg   = 1'b1;
                ex.wr_idx   = rd;
            end
            OP_STR:
            begin
                ex.wr_mem   = 1'b1;
                ex.mem_addr = wrap_addr(17'(a) + 17'(rd));
                ex.mem_val  = b;
            end
            OP_MOV:
            begin
                ex.wr_reg = 1'b1;
                ex.wr_idx = rd;
                ex.wr_val = {8'b0, instr[11:4]};
            end
            OP_ADD, OP_ADDI:
            begin
                ex.wr_reg = 1'b1;
                ex.wr_idx = rd;
                ex.wr_val = sum[15:0];
                ex.z_next = (sum[15:0] == '0);
                ex.c_next = sum[16];
            end
            OP_SUB, OP_SUBI:
            begin
                ex.wr_reg = 1'b1;
                ex.wr_idx = rd;
                ex.wr_val = diff[15:0];
                ex.z_next = (diff[15:0] == '0);
                ex.c_next = diff[16];
            end
            OP_AND, OP_OR, OP_SHR, OP_SHL:
            begin
                ex.wr_reg = 1'b1;
                ex.wr_idx = rd;
                if (op == OP_AND)
                begin
                    ex.wr_val = a & b;
                end
                else if (op == OP_OR)
                begin
                    ex.wr_val = a | b;
                end
                else if (op == OP_SHR)
                begin
                    ex.wr_val = a >> i4;
                end
                else
                begin
                    ex.wr_val = a << i4;
                end
                ex.z_next = (ex.wr_val == '0);
            end
            OP_CMP:
            begin
                ex.z_next = (a == b);
                ex.c_next = diff[16];
            end
            OP_PUSH:
            begin
                ex.wr_mem   = 1'b1;
                ex.mem_addr = wrap_addr(17'(sp));
                ex.mem_val  = b;
                ex.wr_reg   = 1'b1;
                ex.wr_idx   = REG_SP;
                ex.wr_val   = sp - 16'd1;
            end
            OP_POP:
            begin
                if (instr == HALT_WORD)
                begin
                    ex.halt = 1'b1;
                end
                else
                begin
                    ex.sp_next  = sp_inc;
                    ex.mem_rd   = 1'b1;
                    ex.mem_addr = wrap_addr(17'(sp_inc));
                    ex.wr_reg   = 1'b1;
                    ex.wr_idx   = rd;
                end
            end
            default:
            begin
                ex.pc_next = pc;
            end
        endcase
    end

endmodule

FILE: sv/toy_cpu_instruction_step.sv
`timescale 1ns / 1ps

// Channel  Role    Transfer when        Payload
// req      sink    req.valid & ready    req_type, load_addr, load_data
// rsp      source  rsp.valid & ready    pc_value, flags, is_halted, reg_*, mem_*
//
// A load request and a step while halted go from IDLE straight to DONE and the
// result. A step goes through fetch, decode with register-file read, execute
// (with the store or load address), load data for LDR and POP only, and result.
// Reset clears PC, flags and halt, sets SP to the top word and clears the
// register-file valid bits; the word memory is not cleared. One request is in
// flight at a time; a result waiting in the output register does not hold off
// the next request.
module toy_cpu_instruction_step
    import tcpu_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    tcpu_req_if.sink  req,
    tcpu_rsp_if.source rsp
);

    state_t   state_reg, state_next;
    word_t    pc_reg, pc_next;
    word_t    sp_reg, sp_next;
    logic     z_reg, z_next;
    logic     c_reg, c_next;
    logic     halt_reg, halt_next;
    logic     out_valid_reg, out_valid_next;
    word_t    instr_reg, instr_next;
    reg_idx_t ld_idx_reg, ld_idx_next;
    report_t  rep_reg, rep_next;
    rsp_t     out_reg, out_next;

    logic     accept;
    logic     mem_we;
    addr_t    mem_addr;
    word_t    mem_wdata;
    word_t    mem_rdata;
    word_t    rf_a, rf_b;
    word_t    op_a, op_b;
    logic     wb_en;
    reg_idx_t wb_idx;
    word_t    wb_val;
    logic     rf_we;
    exec_t    ex;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;

    // Word memory: instructions and data.
    tcpu_ram #(
        .DEPTH (MEM_WORDS),
        .WIDTH (16)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // General registers; SP and PC live in their own flops.
    assign rf_we = wb_en && (wb_idx != REG_SP) && (wb_idx != REG_PC);

    tcpu_regfile u_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .ra_a  (mem_rdata[11:8]),
        .ra_b  (mem_rdata[7:4]),
        .we    (rf_we),
        .wa    (wb_idx),
        .wd    (wb_val),
        .rd_a  (rf_a),
        .rd_b  (rf_b)
    );

    // Source operands, with SP and PC taken from their flops.
    always_comb
    begin
        if (instr_reg[11:8] == REG_PC)
        begin
            op_a = pc_reg;
        end
        else if (instr_reg[11:8] == REG_SP)
        begin
            op_a = sp_reg;
        end
        else
        begin
            op_a = rf_a;
        end
        if (instr_reg[7:4] == REG_PC)
        begin
            op_b = pc_reg;
        end
        else if (instr_reg[7:4] == REG_SP)
        begin
            op_b = sp_reg;
        end
        else
        begin
            op_b = rf_b;
        end
    end

    tcpu_alu u_alu (
        .instr (instr_reg),
        .a     (op_a),
        .b     (op_b),
        .pc    (pc_reg),
        .sp    (sp_reg),
        .z     (z_reg),
        .c     (c_reg),
        .ex    (ex)
    );

    // Sequencer: next state, memory port and write-back.
    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        sp_next        = sp_reg;
        z_next         = z_reg;
        c_next         = c_reg;
        halt_next      = halt_reg;
        out_valid_next = out_valid_reg;
        instr_next     = instr_reg;
        ld_idx_next    = ld_idx_reg;
        rep_next       = rep_reg;
        out_next       = out_reg;
        mem_we         = 1'b0;
        mem_addr       = wrap_addr(17'(pc_reg));
        mem_wdata      = req.load_data;
        wb_en          = 1'b0;
        wb_idx         = ex.wr_idx;
        wb_val         = ex.wr_val;

        // The waiting result leaves on its transfer.
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rep_next = '0;
                    if (req.req_type == REQ_LOAD)
                    begin
                        mem_we     = 1'b1;
                        mem_addr   = ADDR_W'(req.load_addr);
                        state_next = ST_DONE;
                    end
                    else if (halt_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_DECODE;
                    end
                end
            end
            ST_DECODE:
            begin
                instr_next = mem_rdata;
                pc_next    = pc_reg + 16'd1;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                pc_next   = ex.pc_next;
                sp_next   = ex.sp_next;
                z_next    = ex.z_next;
                c_next    = ex.c_next;
                halt_next = ex.halt;
                mem_we    = ex.wr_mem;
                mem_addr  = ex.mem_addr;
                mem_wdata = ex.mem_val;
                rep_next.reg_written = ex.wr_reg;
                rep_next.reg_index   = ex.wr_idx;
                rep_next.reg_value   = ex.wr_val;
                rep_next.mem_written = ex.wr_mem;
                rep_next.mem_addr    = ex.wr_mem ? 13'(ex.mem_addr) : '0;
                rep_next.mem_value   = ex.mem_val;
                ld_idx_next          = ex.wr_idx;
                if (ex.mem_rd)
                begin
                    state_next = ST_MEM;
                end
                else
                begin
                    wb_en      = ex.wr_reg;
                    state_next = ST_DONE;
                end
            end
            ST_MEM:
            begin
                wb_en              = 1'b1;
                wb_idx             = ld_idx_reg;
                wb_val             = mem_rdata;
                rep_next.reg_value = mem_rdata;
                state_next         = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next          = 1'b1;
                    out_next.pc_value       = pc_reg;
                    out_next.zero_flag_out  = z_reg;
                    out_next.carry_flag_out = c_reg;
                    out_next.is_halted      = halt_reg;
                    out_next.rep            = rep_reg;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A register write to PC or SP wins over the fetch, jump or pop update.
        if (wb_en && (wb_idx == REG_PC))
        begin
            pc_next = wb_val;
        end
        else if (wb_en && (wb_idx == REG_SP))
        begin
            sp_next = wb_val;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            sp_reg        <= SP_RESET;
            z_reg         <= 1'b0;
            c_reg         <= 1'b0;
            halt_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            sp_reg        <= sp_next;
            z_reg         <= z_next;
            c_reg         <= c_next;
            halt_reg      <= halt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        instr_reg  <= instr_next;
        ld_idx_reg <= ld_idx_next;
        rep_reg    <= rep_next;
        out_reg    <= out_next;
    end

    // Result channel.
    assign rsp.valid          = out_valid_reg;
    assign rsp.pc_value       = out_reg.pc_value;
    assign rsp.zero_flag_out  = out_reg.zero_flag_out;
    assign rsp.carry_flag_out = out_reg.carry_flag_out;
    assign rsp.is_halted      = out_reg.is_halted;
    assign rsp.reg_written    = out_reg.rep.reg_written;
    assign rsp.reg_index      = out_reg.rep.reg_index;
    assign rsp.reg_value      = out_reg.rep.reg_value;
    assign rsp.mem_written    = out_reg.rep.mem_written;
    assign rsp.mem_addr       = out_reg.rep.mem_addr;
    assign rsp.mem_value      = out_reg.rep.mem_value;

endmodule
